// ===== design/vertex_transform_4x4_core_macros.svh =====
// Assertion macros for the vertex transform RTL.
// Included by vertex_transform_4x4_core, which checks its own pipeline control; no other dependencies.
`ifndef VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define VT4_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vt4 assertion failed");
`define VT4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vt4 assertion failed");
`else
`define VT4_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define VT4_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/vt4_pkg.sv =====
// Shared constants and types for the 4x4 vertex transform core.
// No dependencies; used by vt4_column and vertex_transform_4x4_core.
package vt4_pkg;

  localparam int NUM_COEFF_REGS = 8;
  localparam int COEFF_SEL_W    = $clog2(NUM_COEFF_REGS);
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 64;
  localparam int COMP_W         = 32;
  localparam int NUM_COMP       = 4;
  localparam int PROD_W         = 2 * COMP_W;
  localparam int SUM1_W         = PROD_W + 1;
  localparam int SUM2_W         = PROD_W + 2;
  localparam int FRAC_BITS      = 16;

  localparam logic [CFG_DATA_W-1:0] COEFF_RESET [NUM_COEFF_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] vec_t;

  typedef struct packed {
    logic mul;
    logic sum1;
    logic sum2;
    logic res;
  } vt4_adv_t;

endpackage

// ===== design/vertex_transform_4x4_core.sv =====
// Top level of the 4x4 vertex transform: matrix registers, pipeline control, four columns.
// Depends on vt4_pkg, vt4_column and vertex_transform_4x4_core_macros.svh.
//
//   channel   dir  handshake                 payload
//   s_        in   s_tvalid / s_tready       s_tdata: in_x, in_y, in_z, in_w
//   m_        out  m_tvalid / m_tready       m_tdata: out_x..out_w, m_tuser: saturated
//   cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One vertex per cycle sustained while m_tready stays high; an input beat passes through, in order:
// multiply, first add, second add, shift and saturate into the output register.
// Each stage holds its beat while the next is full and stalled; bubbles collapse.
// rst clears the stage valid bits and loads the identity matrix. cfg_ready is always high.
`include "vertex_transform_4x4_core_macros.svh"

module vertex_transform_4x4_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [127:0]                         s_tdata,   // in_x, in_y, in_z, in_w
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [127:0]                         m_tdata,   // out_x, out_y, out_z, out_w
  output logic                                 m_tuser,   // saturated
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vt4_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [vt4_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [vt4_pkg::CFG_DATA_W-1:0] mat [vt4_pkg::NUM_COEFF_REGS];
  logic [vt4_pkg::COMP_W-1:0] elem [2*vt4_pkg::NUM_COEFF_REGS];
  vt4_pkg::vec_t col_coef [vt4_pkg::NUM_COMP];
  vt4_pkg::vec_t vec;
  vt4_pkg::vec_t res;
  logic [vt4_pkg::NUM_COMP-1:0] sat;
  vt4_pkg::vt4_adv_t adv;

  logic v_mul;
  logic v_sum1;
  logic v_sum2;
  logic v_res;
  logic rdy_mul;
  logic rdy_sum1;
  logic rdy_sum2;
  logic rdy_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < vt4_pkg::NUM_COEFF_REGS; k++) begin
        mat[k] <= vt4_pkg::COEFF_RESET[k];
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < vt4_pkg::CFG_INDEX_W'(vt4_pkg::NUM_COEFF_REGS)) begin
      mat[cfg_index[vt4_pkg::COEFF_SEL_W-1:0]] <= cfg_data;
    end
  end

  for (genvar k = 0; k < vt4_pkg::NUM_COEFF_REGS; k++) begin : g_elem
    assign elem[2*k]   = mat[k][vt4_pkg::COMP_W-1:0];
    assign elem[2*k+1] = mat[k][vt4_pkg::CFG_DATA_W-1:vt4_pkg::COMP_W];
  end

  // column c takes elements c, c+4, c+8, c+12
  for (genvar c = 0; c < vt4_pkg::NUM_COMP; c++) begin : g_col
    for (genvar r = 0; r < vt4_pkg::NUM_COMP; r++) begin : g_row
      assign col_coef[c][r] = elem[c + vt4_pkg::NUM_COMP*r];
    end
    vt4_column u_col (
      .clk  (clk),
      .adv  (adv),
      .vec  (vec),
      .coef (col_coef[c]),
      .comp (res[c]),
      .sat  (sat[c])
    );
  end

  assign vec = s_tdata;

  assign rdy_res  = !v_res || m_tready;
  assign rdy_sum2 = !v_sum2 || rdy_res;
  assign rdy_sum1 = !v_sum1 || rdy_sum2;
  assign rdy_mul  = !v_mul || rdy_sum1;
  assign s_tready = rdy_mul;

  assign adv.mul  = s_tvalid && rdy_mul;
  assign adv.sum1 = v_mul && rdy_sum1;
  assign adv.sum2 = v_sum1 && rdy_sum2;
  assign adv.res  = v_sum2 && rdy_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul  <= 1'b0;
      v_sum1 <= 1'b0;
      v_sum2 <= 1'b0;
      v_res  <= 1'b0;
    end else begin
      if (rdy_mul) begin
        v_mul <= s_tvalid;
      end
      if (rdy_sum1) begin
        v_sum1 <= v_mul;
      end
      if (rdy_sum2) begin
        v_sum2 <= v_sum1;
      end
      if (rdy_res) begin
        v_res <= v_sum2;
      end
    end
  end

  assign m_tvalid = v_res;
  assign m_tdata  = res;
  assign m_tuser  = |sat;

  `VT4_ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, v_mul)
  `VT4_ASSERT_IMPLY(a_full_stall, clk, rst, v_mul && v_sum1 && v_sum2 && v_res && !m_tready, !s_tready)
  `VT4_ASSERT_NEXT(a_sum2_holds, clk, rst, v_sum2 && !rdy_res, v_sum2 && v_res)
  `VT4_ASSERT_IMPLY(a_res_from_sum2, clk, rst, $rose(v_res), $past(v_sum2))

endmodule

// ===== design/vt4_column.sv =====
// One output column: four products, two adder levels, floor shift and saturation.
// Depends on vt4_pkg; stage loads are driven by the top-level pipeline control.
module vt4_column (
  input  logic                     clk,
  input  vt4_pkg::vt4_adv_t        adv,
  input  vt4_pkg::vec_t            vec,
  input  vt4_pkg::vec_t            coef,
  output logic [vt4_pkg::COMP_W-1:0] comp,
  output logic                     sat
);

  logic signed [vt4_pkg::PROD_W-1:0] prod [vt4_pkg::NUM_COMP];
  logic signed [vt4_pkg::SUM1_W-1:0] sum1 [2];
  logic signed [vt4_pkg::SUM2_W-1:0] sum2;
  logic signed [vt4_pkg::PROD_W-1:0] prod_next [vt4_pkg::NUM_COMP];
  logic [vt4_pkg::SUM2_W-1:vt4_pkg::FRAC_BITS+vt4_pkg::COMP_W-1] top_bits;
  logic sat_next;
  logic [vt4_pkg::COMP_W-1:0] comp_next;

  always_comb begin
    for (int r = 0; r < vt4_pkg::NUM_COMP; r++) begin
      prod_next[r] = $signed(vec[r]) * $signed(coef[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      for (int r = 0; r < vt4_pkg::NUM_COMP; r++) begin
        prod[r] <= prod_next[r];
      end
    end
    if (adv.sum1) begin
      sum1[0] <= vt4_pkg::SUM1_W'(prod[0]) + vt4_pkg::SUM1_W'(prod[1]);
      sum1[1] <= vt4_pkg::SUM1_W'(prod[2]) + vt4_pkg::SUM1_W'(prod[3]);
    end
    if (adv.sum2) begin
      sum2 <= vt4_pkg::SUM2_W'(sum1[0]) + vt4_pkg::SUM2_W'(sum1[1]);
    end
    if (adv.res) begin
      comp <= comp_next;
      sat  <= sat_next;
    end
  end

  // floor shift is a bit-select; clip when the result's sign bit and the bits above it disagree
  always_comb begin
    top_bits = sum2[vt4_pkg::SUM2_W-1:vt4_pkg::FRAC_BITS+vt4_pkg::COMP_W-1];
    sat_next = !((&top_bits) || !(|top_bits));
    if (!sat_next) begin
      comp_next = sum2[vt4_pkg::FRAC_BITS+vt4_pkg::COMP_W-1:vt4_pkg::FRAC_BITS];
    end else if (sum2[vt4_pkg::SUM2_W-1]) begin
      comp_next = {1'b1, {(vt4_pkg::COMP_W-1){1'b0}}};
    end else begin
      comp_next = {1'b0, {(vt4_pkg::COMP_W-1){1'b1}}};
    end
  end

endmodule
